// File: src/jpeg_block_huffman_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// jpeg_block_huffman_encoder_top_defines.svh
// assertion macros used by the checker file of the entropy encoder
// ----------------------------------------------------------------------------
`ifndef JPEG_BLOCK_HUFFMAN_ENCODER_TOP_DEFINES_SVH
`define JPEG_BLOCK_HUFFMAN_ENCODER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define JBHE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define JBHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/jbhe_pkg.sv
// ----------------------------------------------------------------------------
// jbhe_pkg
// shared constants, types and the standard huffman code tables
// ----------------------------------------------------------------------------
package jbhe_pkg;

    localparam int BLOCK_COEFS        = 64;
    localparam int POS_W              = 6;
    localparam int NUM_COMPONENTS_DEF = 3;
    localparam int COEF_W             = 11;
    localparam int ACC_W              = 23;
    localparam int CNT_W              = 5;
    localparam logic [7:0]  SYM_ZRL    = 8'hF0;
    localparam logic [7:0]  SYM_EOB    = 8'h00;
    localparam logic [7:0]  BYTE_FF    = 8'hFF;
    localparam logic [7:0]  BYTE_STUFF = 8'h00;
    localparam logic [15:0] FLUSH_CODE = 16'h007F;
    localparam logic [4:0]  FLUSH_LEN  = 5'd7;

    // one code word: length and right-aligned code
    typedef struct packed {
        logic [4:0]  len;
        logic [15:0] code;
    } huff_ent_t;

    typedef huff_ent_t [0:255] huff_tab_t;

    // operations handed from the symbol stage to the sequencer
    typedef struct packed {
        logic [1:0]  zrl_cnt;
        huff_ent_t   zrl;
        huff_ent_t   sym;
        logic [10:0] mag_bits;
        logic [4:0]  mag_len;
        logic        pos_adv;
        logic        dc_upd;
        logic [5:0]  run_next;
    } sym_op_t;

    // sequencer to packer
    typedef struct packed {
        logic        put;
        logic [15:0] code;
        logic [4:0]  len;
        logic        gen;
        logic        fin;
        logic        clear;
    } pk_ctl_t;

    // packer to sequencer
    typedef struct packed {
        logic byte_avail;
        logic ok;
    } pk_sts_t;

    localparam logic [0:15][7:0] DC_CNT_Y = {8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                             8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam logic [0:15][7:0] DC_CNT_C = {8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                             8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam logic [0:15][7:0] AC_CNT_Y = {8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
                                             8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
    localparam logic [0:15][7:0] AC_CNT_C = {8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
                                             8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

    localparam logic [0:161][7:0] AC_SYM_Y = {
        8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
        8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,
        8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,
        8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
        8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,
        8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
        8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
        8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,
        8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
        8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,
        8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
        8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,8'hf4,
        8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

    localparam logic [0:161][7:0] AC_SYM_C = {
        8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,
        8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,
        8'ha1,8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,
        8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,
        8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,
        8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
        8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
        8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,
        8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
        8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
        8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,8'hf4,
        8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

    // canonical code assignment from the length counts, run at elaboration
    function automatic huff_tab_t build_tab(input logic [0:15][7:0] counts,
                                            input logic [0:161][7:0] syms,
                                            input logic by_index);
        huff_tab_t tab;
        int code;
        int sym;
        int idx;
        tab  = '0;
        code = 0;
        sym  = 0;
        for (int len = 1; len <= 16; len++)
        begin
            for (int k = 0; k < int'(counts[len-1]); k++)
            begin
                if (sym < 162)
                begin
                    idx = by_index ? sym : int'(syms[sym]);
                    tab[idx].len  = 5'(len);
                    tab[idx].code = 16'(code);
                    sym++;
                    code++;
                end
            end
            code = code << 1;
        end
        return tab;
    endfunction

    localparam huff_tab_t DC_TAB_Y = build_tab(DC_CNT_Y, AC_SYM_Y, 1'b1);
    localparam huff_tab_t DC_TAB_C = build_tab(DC_CNT_C, AC_SYM_C, 1'b1);
    localparam huff_tab_t AC_TAB_Y = build_tab(AC_CNT_Y, AC_SYM_Y, 1'b0);
    localparam huff_tab_t AC_TAB_C = build_tab(AC_CNT_C, AC_SYM_C, 1'b0);

endpackage

// File: src/jbhe_symbol.sv
// ----------------------------------------------------------------------------
// jbhe_symbol
// maps one coefficient or flush command to its huffman symbols, magnitude bits and state update
// ----------------------------------------------------------------------------
module jbhe_symbol import jbhe_pkg::*;
(
    input  logic                     cmd,
    input  logic                     in_range,
    input  logic [1:0]               component,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [COEF_W-1:0] pred,
    input  logic [POS_W-1:0]         position,
    input  logic [5:0]               zero_run,
    output sym_op_t                  op
);

    logic               is_dc;
    logic               is_zero;
    logic               is_eob;
    logic               chroma;
    logic signed [11:0] coef_sat;
    logic signed [11:0] val;
    logic signed [11:0] mag_raw;
    logic [10:0]        abs_val;
    logic [10:0]        mask;
    logic [3:0]         size;
    huff_ent_t          dc_ent;
    huff_ent_t          ac_ent;
    huff_ent_t          eob_ent;
    huff_ent_t          zrl_ent;
    logic [7:0]         ac_idx;

    assign is_dc   = (position == '0);
    assign is_zero = (coef == '0);
    assign is_eob  = (position == POS_W'(BLOCK_COEFS - 1));
    assign chroma  = (component != 2'd0);

    // value to code: dc difference or saturated ac value
    assign coef_sat = (coef == $signed(11'h400)) ? -12'sd1023 : 12'(coef);
    assign val      = is_dc ? (12'(coef) - 12'(pred)) : coef_sat;
    assign abs_val  = val[11] ? 11'(-val) : val[10:0];
    assign mag_raw  = val[11] ? (val - 12'sd1) : val;

    // size category from the highest set bit
    always_comb
    begin
        size = '0;
        for (int i = 0; i < 11; i++)
        begin
            if (abs_val[i])
            begin
                size = 4'(i + 1);
            end
        end
    end

    assign mask   = 11'((12'd1 << size) - 12'd1);
    assign ac_idx = {zero_run[3:0], size};

    // table lookups
    assign dc_ent  = chroma ? DC_TAB_C[8'(size)] : DC_TAB_Y[8'(size)];
    assign ac_ent  = chroma ? AC_TAB_C[ac_idx]   : AC_TAB_Y[ac_idx];
    assign eob_ent = chroma ? AC_TAB_C[SYM_EOB]  : AC_TAB_Y[SYM_EOB];
    assign zrl_ent = chroma ? AC_TAB_C[SYM_ZRL]  : AC_TAB_Y[SYM_ZRL];

    // operation list for this item
    always_comb
    begin
        op          = '0;
        op.zrl      = zrl_ent;
        op.run_next = zero_run;
        priority if (cmd)
        begin
            op.sym.code = FLUSH_CODE;
            op.sym.len  = FLUSH_LEN;
        end
        else if (!in_range)
        begin
            op.pos_adv = 1'b0;
        end
        else if (is_dc)
        begin
            op.sym      = dc_ent;
            op.mag_bits = mag_raw[10:0] & mask;
            op.mag_len  = 5'(size);
            op.pos_adv  = 1'b1;
            op.dc_upd   = 1'b1;
            op.run_next = '0;
        end
        else if (is_zero)
        begin
            op.pos_adv  = 1'b1;
            if (is_eob)
            begin
                op.sym      = eob_ent;
                op.run_next = '0;
            end
            else
            begin
                op.run_next = zero_run + 6'd1;
            end
        end
        else
        begin
            op.zrl_cnt  = zero_run[5:4];
            op.sym      = ac_ent;
            op.mag_bits = mag_raw[10:0] & mask;
            op.mag_len  = 5'(size);
            op.pos_adv  = 1'b1;
            op.run_next = '0;
        end
    end

endmodule

// File: src/jbhe_packer.sv
// ----------------------------------------------------------------------------
// jbhe_packer
// shared shift unit: appends codes msb first, cuts bytes, stuffs after 0xff
// ----------------------------------------------------------------------------
module jbhe_packer import jbhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pk_ctl_t    ctl,
    output pk_sts_t    sts,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic       m_axis_tlast
);

    logic [ACC_W-1:0] acc_reg,   acc_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             stuff_reg, stuff_next;
    logic [7:0]       hold_reg,  hold_next;
    logic             have_reg,  have_next;
    logic             ovalid_reg, ovalid_next;
    logic [7:0]       odata_reg, odata_next;
    logic             olast_reg, olast_next;

    logic             out_free;
    logic [ACC_W-1:0] extract;
    logic [7:0]       new_byte;

    assign out_free       = !ovalid_reg || m_axis_tready;
    assign sts.byte_avail = stuff_reg || (cnt_reg >= CNT_W'(8));
    assign sts.ok         = !have_reg || out_free;

    // byte at the top of the pending bits
    assign extract  = acc_reg >> (cnt_reg - CNT_W'(8));
    assign new_byte = stuff_reg ? BYTE_STUFF : extract[7:0];

    always_comb
    begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        stuff_next  = stuff_reg;
        hold_next   = hold_reg;
        have_next   = have_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;

        // output register drains on transfer
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        // append a code
        if (ctl.put)
        begin
            acc_next = ACC_W'((acc_reg << ctl.len) | ACC_W'(ctl.code));
            cnt_next = cnt_reg + ctl.len;
        end

        // cut a byte into the hold stage, pushing the older one out
        if (ctl.gen && sts.ok)
        begin
            if (stuff_reg)
            begin
                stuff_next = 1'b0;
            end
            else
            begin
                cnt_next   = cnt_reg - CNT_W'(8);
                stuff_next = (new_byte == BYTE_FF);
            end
            if (have_reg)
            begin
                ovalid_next = 1'b1;
                odata_next  = hold_reg;
                olast_next  = 1'b0;
            end
            hold_next = new_byte;
            have_next = 1'b1;
        end

        // end of item: last held byte goes out with tlast
        if (ctl.fin && sts.ok)
        begin
            if (have_reg)
            begin
                ovalid_next = 1'b1;
                odata_next  = hold_reg;
                olast_next  = 1'b1;
            end
            have_next = 1'b0;
            if (ctl.clear)
            begin
                acc_next   = '0;
                cnt_next   = '0;
                stuff_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            stuff_reg  <= 1'b0;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            stuff_reg  <= stuff_next;
            have_reg   <= have_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// File: src/jpeg_block_huffman_encoder_top.sv
// ----------------------------------------------------------------------------
// jpeg_block_huffman_encoder_top
// baseline huffman entropy coder for 8x8 blocks of zigzag coefficients
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser                      tlast
//  s_axis    in   coef[10:0]            cmd[0], component[2:1]     -
//  m_axis    out  out_byte[7:0]         -                          last byte of item
//
//  one item at a time: an accept step, a symbol step, then one step per code
//  put (up to three zrl codes, symbol, magnitude) and one per byte cut
//  (stuffed zeros included), plus one closing step, all through the single
//  shift unit and the one-byte output port.
//  a full output register stalls the sequencer.
//  reset clears predictors, block position, zero run and pending bits.
// ----------------------------------------------------------------------------
module jpeg_block_huffman_encoder_top import jbhe_pkg::*;
#(
    parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // coef[10:0], zero fill [15:11]
    input  logic [2:0]  s_axis_tuser,   // cmd[0], component[2:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast
);

    localparam int CIDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_ZRL  = 3'd2;
    localparam logic [2:0] ST_SYM  = 3'd3;
    localparam logic [2:0] ST_MAG  = 3'd4;
    localparam logic [2:0] ST_END  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic                     cmd_reg;
    logic [1:0]               comp_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] pred_reg [NUM_COMPONENTS];
    logic [POS_W-1:0]         pos_reg,   pos_next;
    logic [5:0]               run_reg,   run_next;
    sym_op_t                  op_reg;
    logic [1:0]               zcnt_reg,  zcnt_next;

    logic                     in_range;
    logic [CIDX_W-1:0]        pidx;
    sym_op_t                  op;
    pk_ctl_t                  ctl;
    pk_sts_t                  sts;
    logic                     accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_range      = (32'(comp_reg) < NUM_COMPONENTS);
    assign pidx          = in_range ? comp_reg[CIDX_W-1:0] : '0;

    jbhe_symbol u_symbol
    (
        .cmd       (cmd_reg),
        .in_range  (in_range),
        .component (comp_reg),
        .coef      (coef_reg),
        .pred      (pred_reg[pidx]),
        .position  (pos_reg),
        .zero_run  (run_reg),
        .op        (op)
    );

    jbhe_packer u_packer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        run_next   = run_reg;
        zcnt_next  = zcnt_reg;
        ctl        = '0;
        ctl.clear  = cmd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                zcnt_next = op.zrl_cnt;
                if (cmd_reg)
                begin
                    pos_next = '0;
                    run_next = '0;
                end
                else if (op.pos_adv)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    run_next = op.run_next;
                end
                if (op.zrl_cnt != 2'd0)
                begin
                    state_next = ST_ZRL;
                end
                else if (op.sym.len != '0)
                begin
                    state_next = ST_SYM;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_ZRL, ST_SYM, ST_MAG, ST_END:
            begin
                if (sts.byte_avail)
                begin
                    ctl.gen = 1'b1;
                end
                else
                begin
                    priority case (state_reg)
                        ST_ZRL:
                        begin
                            ctl.put   = 1'b1;
                            ctl.code  = op_reg.zrl.code;
                            ctl.len   = op_reg.zrl.len;
                            zcnt_next = zcnt_reg - 2'd1;
                            if (zcnt_reg == 2'd1)
                            begin
                                state_next = ST_SYM;
                            end
                        end
                        ST_SYM:
                        begin
                            ctl.put    = 1'b1;
                            ctl.code   = op_reg.sym.code;
                            ctl.len    = op_reg.sym.len;
                            state_next = ST_MAG;
                        end
                        ST_MAG:
                        begin
                            ctl.put    = 1'b1;
                            ctl.code   = 16'(op_reg.mag_bits);
                            ctl.len    = op_reg.mag_len;
                            state_next = ST_END;
                        end
                        default:
                        begin
                            ctl.fin = 1'b1;
                            if (sts.ok)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            run_reg   <= '0;
            zcnt_reg  <= '0;
            for (int i = 0; i < NUM_COMPONENTS; i++)
            begin
                pred_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            run_reg   <= run_next;
            zcnt_reg  <= zcnt_next;
            // predictor update on dc items, cleared by flush
            if (state_reg == ST_CALC)
            begin
                if (cmd_reg)
                begin
                    for (int i = 0; i < NUM_COMPONENTS; i++)
                    begin
                        pred_reg[i] <= '0;
                    end
                end
                else if (op.dc_upd)
                begin
                    pred_reg[pidx] <= coef_reg;
                end
            end
        end
    end

    // item payload and operation list
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_axis_tuser[0];
            comp_reg <= s_axis_tuser[2:1];
            coef_reg <= s_axis_tdata[COEF_W-1:0];
        end
        if (state_reg == ST_CALC)
        begin
            op_reg <= op;
        end
    end

endmodule

// File: src/jbhe_checker.sv
// ----------------------------------------------------------------------------
// jbhe_checker
// port-level checks of the entropy coder, bound to the top level
// ----------------------------------------------------------------------------
`include "jpeg_block_huffman_encoder_top_defines.svh"

module jbhe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    logic ff_seen_reg;
    logic out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // remembers that the last transferred byte was 0xff
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_seen_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            ff_seen_reg <= (m_axis_tdata == 8'hFF);
        end
    end

    `JBHE_ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `JBHE_ASSERT_SAME(a_stuff_byte, clk, rst_n, out_xfer && ff_seen_reg, m_axis_tdata == 8'h00)
    `JBHE_ASSERT_SAME(a_ff_not_last, clk, rst_n, out_xfer && m_axis_tdata == 8'hFF, !m_axis_tlast)
    `JBHE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind jpeg_block_huffman_encoder_top jbhe_checker u_jbhe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: sim/jbhe_scan_checker.sv
// ----------------------------------------------------------------------------
// jbhe_scan_checker
// watches both stream channels of the entropy encoder, predicts the coded
// scan bytes from each accepted input transfer and compares them in order
// ----------------------------------------------------------------------------
module jbhe_scan_checker import jbhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fails,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES = 16;
    localparam int CMD_FLUSH = 1;

    typedef struct packed {
        logic [7:0] value;
        logic       tail;
    } scan_byte_t;

    scan_byte_t scan_bytes_q[$];

    // code tables, index 0 luminance, 1 chrominance
    logic [15:0] dc_code [2][16];
    logic [4:0]  dc_len  [2][16];
    logic [15:0] ac_code [2][256];
    logic [4:0]  ac_len  [2][256];

    // encoder state copy
    int          dc_pred [3];
    int          blk_pos;
    int          zrun;
    logic [31:0] bit_hold;
    int          bit_cnt;

    scan_byte_t  item_bytes [MAX_BYTES];
    int          item_n;

    assign outstanding = scan_bytes_q.size();

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fails++;
    endtask

    task automatic load_tables();
        int code;
        int sym;
        for (int t = 0; t < 2; t++)
        begin
            for (int i = 0; i < 16; i++)
            begin
                dc_code[t][i] = '0;
                dc_len[t][i]  = '0;
            end
            for (int i = 0; i < 256; i++)
            begin
                ac_code[t][i] = '0;
                ac_len[t][i]  = '0;
            end
            code = 0;
            sym  = 0;
            for (int len = 1; len <= 16; len++)
            begin
                for (int k = 0; k < int'(t ? DC_CNT_C[len-1] : DC_CNT_Y[len-1]); k++)
                begin
                    dc_code[t][sym & 15] = 16'(code);
                    dc_len[t][sym & 15]  = 5'(len);
                    sym++;
                    code++;
                end
                code = code << 1;
            end
            code = 0;
            sym  = 0;
            for (int len = 1; len <= 16; len++)
            begin
                for (int k = 0; k < int'(t ? AC_CNT_C[len-1] : AC_CNT_Y[len-1]); k++)
                begin
                    if (sym < 162)
                    begin
                        ac_code[t][t ? AC_SYM_C[sym] : AC_SYM_Y[sym]] = 16'(code);
                        ac_len[t][t ? AC_SYM_C[sym] : AC_SYM_Y[sym]]  = 5'(len);
                        sym++;
                        code++;
                    end
                end
                code = code << 1;
            end
        end
    endtask

    task automatic clear_coder();
        for (int c = 0; c < 3; c++)
            dc_pred[c] = 0;
        blk_pos  = 0;
        zrun     = 0;
        bit_hold = '0;
        bit_cnt  = 0;
    endtask

    task automatic add_byte(input logic [7:0] b);
        if (item_n < MAX_BYTES)
        begin
            item_bytes[item_n] = '{value: b, tail: 1'b0};
            item_n++;
        end
    endtask

    // append bits msb first, cutting whole bytes with ff stuffing
    task automatic pack_bits(input logic [31:0] code, input int len);
        logic [31:0] acc;
        logic [7:0]  b;
        int          cnt;
        acc = (bit_hold << len) | (code & ((32'd1 << len) - 1));
        cnt = bit_cnt + len;
        while (cnt >= 8)
        begin
            b = 8'(acc >> (cnt - 8));
            add_byte(b);
            if (b == BYTE_FF)
                add_byte(BYTE_STUFF);
            cnt -= 8;
        end
        bit_hold = acc & ((32'd1 << cnt) - 1);
        bit_cnt  = cnt;
    endtask

    function automatic int mag_size(input int v);
        int a;
        int s;
        a = (v < 0) ? -v : v;
        s = 0;
        while (a != 0)
        begin
            s++;
            a = a >> 1;
        end
        return s;
    endfunction

    task automatic pack_magnitude(input int v, input int s);
        if (s != 0)
            pack_bits(32'(v < 0 ? v - 1 : v) & ((32'd1 << s) - 1), s);
    endtask

    // expected scan bytes for one accepted input item
    task automatic encode_item(input logic flush, input logic [1:0] comp,
                               input logic signed [10:0] coef);
        int v;
        int diff;
        int s;
        int t;
        int sym;
        item_n = 0;
        v = int'(coef);
        if (flush)
        begin
            pack_bits(32'(FLUSH_CODE), int'(FLUSH_LEN));
            clear_coder();
        end
        else if (comp < 3)
        begin
            t = (comp != 0) ? 1 : 0;
            if (blk_pos == 0)
            begin
                diff = v - dc_pred[comp];
                s = mag_size(diff);
                dc_pred[comp] = v;
                zrun = 0;
                pack_bits(32'(dc_code[t][s & 15]), int'(dc_len[t][s & 15]));
                pack_magnitude(diff, s);
            end
            else if (v == 0)
            begin
                zrun++;
                if (blk_pos == BLOCK_COEFS - 1)
                begin
                    pack_bits(32'(ac_code[t][SYM_EOB]), int'(ac_len[t][SYM_EOB]));
                    zrun = 0;
                end
            end
            else
            begin
                // -1024 has no ac symbol, saturate
                if (v < -1023)
                    v = -1023;
                while (zrun >= 16)
                begin
                    pack_bits(32'(ac_code[t][SYM_ZRL]), int'(ac_len[t][SYM_ZRL]));
                    zrun -= 16;
                end
                s = mag_size(v);
                sym = ((zrun << 4) | s) & 8'hFF;
                pack_bits(32'(ac_code[t][sym]), int'(ac_len[t][sym]));
                pack_magnitude(v, s);
                zrun = 0;
            end
            blk_pos = (blk_pos + 1) % BLOCK_COEFS;
        end
        if (item_n > 0)
            item_bytes[item_n-1].tail = 1'b1;
        for (int i = 0; i < item_n; i++)
            scan_bytes_q.push_back(item_bytes[i]);
    endtask

    initial
    begin
        fails = 0;
        load_tables();
        clear_coder();
    end

    // sample both channels at the clock edge
    always @(posedge clk)
    begin
        scan_byte_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                encode_item(s_axis_tuser[0] == CMD_FLUSH, s_axis_tuser[2:1],
                            s_axis_tdata[10:0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (scan_bytes_q.size() == 0)
                    report($sformatf("unexpected byte %02h", m_axis_tdata));
                else
                begin
                    want = scan_bytes_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report($sformatf("byte %02h, expected %02h",
                                         m_axis_tdata, want.value));
                    if (m_axis_tlast !== want.tail)
                        report($sformatf("tlast %b, expected %b on byte %02h",
                                         m_axis_tlast, want.tail, want.value));
                end
            end
        end
    end

endmodule

// File: sim/tb_jpeg_block_huffman_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_jpeg_block_huffman_encoder_top
// drives coefficient blocks and flushes into the entropy encoder under
// several sender and receiver idling mixes; the scan checker predicts and
// compares every output byte, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_jpeg_block_huffman_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  ITEM_GOAL   = 460;
    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int fails;
    int outstanding;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int cycles;
    int coded_items;

    jpeg_block_huffman_encoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    jbhe_scan_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fails         (fails),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // timeout watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_jpeg_block_huffman_encoder_top failed");
                $finish;
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one input transfer, then sometimes a random sender gap
    task automatic send(input logic cmd, input logic [1:0] comp,
                        input logic [10:0] coef);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {comp, cmd};
        s_axis_tdata  <= {5'b0, coef};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == CMD_FLUSH || comp < 2'd3)
            coded_items++;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [10:0] any_coef();
        return 11'($urandom_range(2047));
    endfunction

    // sparse ac value: mostly zero, else small or anywhere in range
    function automatic logic [10:0] ac_coef();
        int r;
        r = $urandom_range(99);
        if (r < 78)
            return 11'd0;
        if (r < 95)
            return 11'($urandom_range(1, 15) * ($urandom_range(1) ? 1 : -1));
        return any_coef();
    endfunction

    // one block, possibly cut short or sprinkled with ignored items
    task automatic random_block(input logic broken);
        logic [1:0] comp;
        int         stop_at;
        comp = 2'($urandom_range(2));
        stop_at = broken ? $urandom_range(1, 62) : 64;
        for (int k = 0; k < stop_at; k++)
        begin
            if ($urandom_range(99) < 3)
                send(CMD_COEF, 2'd3, any_coef());
            // occasional mixed component inside the block
            if (k > 0 && $urandom_range(99) < 4)
                send(CMD_COEF, 2'($urandom_range(2)), ac_coef());
            else
                send(CMD_COEF, comp, (k == 0) ? any_coef() : ac_coef());
        end
        if (broken || $urandom_range(99) < 15)
            send(CMD_FLUSH, 2'($urandom_range(3)), any_coef());
    endtask

    initial
    begin
        int blk;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        coded_items   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dc extremes, ac extremes, -1024, long zero runs, eob,
        // ignored component, chroma tables, flushes
        send(CMD_COEF, 2'd0, 11'h3FF);
        send(CMD_COEF, 2'd0, 11'h400);
        send(CMD_COEF, 2'd0, 11'h3FF);
        for (int k = 3; k < 40; k++)
            send(CMD_COEF, 2'd0, 11'd0);
        send(CMD_COEF, 2'd3, 11'h7FF);
        send(CMD_COEF, 2'd0, 11'h001);
        for (int k = 41; k < 64; k++)
            send(CMD_COEF, 2'd0, 11'd0);
        send(CMD_COEF, 2'd1, 11'h400);
        send(CMD_COEF, 2'd2, 11'h3FF);
        send(CMD_COEF, 2'd1, 11'h7FF);
        send(CMD_FLUSH, 2'd0, 11'd0);
        send(CMD_FLUSH, 2'd2, 11'h555);
        wait_drained();

        // random blocks over the idling mixes
        blk = 0;
        while (coded_items < ITEM_GOAL)
        begin
            case (blk % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (blk == 2)
                hold_left = 300;
            random_block($urandom_range(99) < 30);
            // sender pause until everything is out
            if (blk == 3)
                wait_drained();
            blk++;
        end
        send(CMD_FLUSH, 2'd0, 11'd0);
        wait_drained();

        if (fails == 0 && outstanding == 0)
            $display("tb_jpeg_block_huffman_encoder_top passed");
        else
            $display("tb_jpeg_block_huffman_encoder_top failed");
        $finish;
    end

endmodule
